>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the positional list engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PLC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always condition");

// Check a same-cycle implication outside reset.
`define PLC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Check a next-cycle implication outside reset.
`define PLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/plc_pkg.sv
// ---------------------------------------------------------------------------
// plc_pkg
// Types and codes shared by the positional list engine modules.
// ---------------------------------------------------------------------------
package plc_pkg;

   // Field widths of the request and response beats
   localparam int FUNC_W  = 3;
   localparam int WORD_W  = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   // Request operation codes; the remaining code is ignored
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD_FRONT    = 3'd0,
      FUNC_ADD_END      = 3'd1,
      FUNC_INSERT_AT    = 3'd2,
      FUNC_REMOVE_FRONT = 3'd3,
      FUNC_REMOVE_END   = 3'd4,
      FUNC_REMOVE_AT    = 3'd5,
      FUNC_CLEAR        = 3'd6
   } func_type;

   // Shift command broadcast along the cell chain
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_kind_type;

endpackage

>>> hdl/plc_if.sv
// ---------------------------------------------------------------------------
// plc_if
// Valid/ready channels for request and response beats.
// ---------------------------------------------------------------------------
interface plc_req_if;
   logic                               valid;
   logic                               ready;
   logic [plc_pkg::FUNC_W-1:0]         func;
   logic signed [plc_pkg::WORD_W-1:0]  value_in;
   logic [plc_pkg::POS_W-1:0]          position;

   modport source (output valid, func, value_in, position, input ready);
   modport sink   (input valid, func, value_in, position, output ready);
endinterface

interface plc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic signed [plc_pkg::WORD_W-1:0]  removed_value;
   logic [plc_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, ok, removed_value, entry_count, input ready);
   modport sink   (input valid, ok, removed_value, entry_count, output ready);
endinterface

>>> hdl/plc_cell.sv
// ---------------------------------------------------------------------------
// plc_cell
// One list slot: holds a word and shifts with its neighbors on insert/remove.
// ---------------------------------------------------------------------------
module plc_cell #(
   parameter int INDEX  = 0,
   parameter int SLOT_W = 6
) (
   input  logic                             clock,
   input  plc_pkg::op_kind_type             op_kind,
   input  logic [SLOT_W-1:0]                slot,
   input  logic [plc_pkg::WORD_W-1:0]       word_new,
   input  logic [plc_pkg::WORD_W-1:0]       word_left,
   input  logic [plc_pkg::WORD_W-1:0]       word_right,
   output logic [plc_pkg::WORD_W-1:0]       word_out,
   output logic [plc_pkg::WORD_W-1:0]       tap_out
);
   import plc_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // Pick the next word: load, shift up from the left, or shift down from the right
   always_comb begin
      word_in = word_ff;
      case (op_kind)
         OP_INSERT: begin
            if (MY_SLOT == slot) begin
               word_in = word_new;
            end else if (MY_SLOT > slot) begin
               word_in = word_left;
            end
         end
         OP_REMOVE: begin
            if (MY_SLOT >= slot) begin
               word_in = word_right;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // Hold the slot word
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

   // Drive the word onto the read bus only when this slot is addressed
   assign tap_out = (MY_SLOT == slot) ? word_ff : '0;

endmodule

>>> hdl/plc_chain.sv
// ---------------------------------------------------------------------------
// plc_chain
// Row of list cells with neighbor links and an OR-combined read tap.
// ---------------------------------------------------------------------------
module plc_chain #(
   parameter int CAPACITY = 64,
   parameter int SLOT_W   = 6
) (
   input  logic                             clock,
   input  plc_pkg::op_kind_type             op_kind,
   input  logic [SLOT_W-1:0]                slot,
   input  logic [plc_pkg::WORD_W-1:0]       word_new,
   output logic [plc_pkg::WORD_W-1:0]       tap_word
);
   import plc_pkg::*;

   logic [WORD_W-1:0] words [CAPACITY];
   logic [WORD_W-1:0] taps  [CAPACITY];

   // Build the cell row; the ends link to the new word and to themselves
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = word_new;
      end else begin : g_mid_l
         assign left_word = words[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_mid_r
         assign right_word = words[i+1];
      end

      plc_cell #(
         .INDEX  (i),
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock      (clock),
         .op_kind    (op_kind),
         .slot       (slot),
         .word_new   (word_new),
         .word_left  (left_word),
         .word_right (right_word),
         .word_out   (words[i]),
         .tap_out    (taps[i])
      );
   end

   // Combine the taps; at most one cell drives a nonzero word
   always_comb begin
      tap_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_word = tap_word | taps[i];
      end
   end

endmodule

>>> hdl/positional_list_engine_top.sv
// A response beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the response sink takes beats; every cell shifts in the same cycle.
// A response waiting in the output register does not block a new request
// when the sink takes it in that cycle.
// Reset clears the entry count and the response valid; cell words are not cleared.
// ---------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list with front/end/positional insert and remove.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   plc_req_if.sink     req_bus,
   plc_rsp_if.source   rsp_bus
);
   import plc_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_ok_ff;
   logic               rsp_ok_in;
   logic [WORD_W-1:0]  rsp_removed_ff;
   logic [WORD_W-1:0]  rsp_removed_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;

   logic               accept;
   func_type           func;
   logic [CMP_W-1:0]   count_x;
   logic [CMP_W-1:0]   pos_x;
   logic               full;
   logic               empty;
   op_kind_type        op_kind;
   logic [SLOT_W-1:0]  slot;
   logic               ok;
   logic [WORD_W-1:0]  tap_word;

   // Take a request when the response slot is free or being drained
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign func    = func_type'(req_bus.func);
   assign count_x = CMP_W'(count_ff);
   assign pos_x   = CMP_W'(req_bus.position);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);

   // Decode the request into a chain command, a slot and the new count
   always_comb begin
      ok       = 1'b0;
      op_kind  = OP_HOLD;
      slot     = '0;
      count_in = count_ff;
      case (func)
         FUNC_ADD_FRONT: begin
            ok = !full;
         end
         FUNC_ADD_END: begin
            ok   = !full;
            slot = SLOT_W'(count_ff);
         end
         FUNC_INSERT_AT: begin
            ok   = !full && (pos_x != '0) && (pos_x <= count_x + CMP_W'(1));
            slot = SLOT_W'(pos_x - CMP_W'(1));
         end
         FUNC_REMOVE_FRONT: begin
            ok = !empty;
         end
         FUNC_REMOVE_END: begin
            ok   = !empty;
            slot = SLOT_W'(count_ff - CNT_W'(1));
         end
         FUNC_REMOVE_AT: begin
            ok   = !empty && (pos_x != '0) && (pos_x <= count_x);
            slot = SLOT_W'(pos_x - CMP_W'(1));
         end
         FUNC_CLEAR: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (accept && ok) begin
         case (func)
            FUNC_ADD_FRONT, FUNC_ADD_END, FUNC_INSERT_AT: begin
               op_kind  = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
            FUNC_REMOVE_FRONT, FUNC_REMOVE_END, FUNC_REMOVE_AT: begin
               op_kind  = OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   plc_chain #(
      .CAPACITY (CAPACITY),
      .SLOT_W   (SLOT_W)
   ) u_chain (
      .clock    (clock),
      .op_kind  (op_kind),
      .slot     (slot),
      .word_new (req_bus.value_in),
      .tap_word (tap_word)
   );

   // Form the next response beat
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = ok;
         rsp_removed_in = (op_kind == OP_REMOVE) ? tap_word : '0;
         rsp_count_in   = COUNT_W'(count_in);
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.ok            = rsp_ok_ff;
   assign rsp_bus.removed_value = rsp_removed_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

   // Count never passes the capacity
   `PLC_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   // A rejected request leaves the count alone
   `PLC_ASSERT_NEXT(a_reject_keeps_count, clock, reset, accept && !ok, $stable(count_ff))
   // Every accepted request yields a response beat next cycle
   `PLC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff)
   // A failed response carries no removed word
   `PLC_ASSERT_IMPLY(a_fail_zero_word, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_removed_ff == '0)

endmodule

>>> tb/tb_positional_list_engine_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. Drives request beats
// through the valid/ready channel, keeps a shadow copy of the list to work
// out each response, and compares every response beat field by field.
// Covers the empty and full list, bad positions, the unused code, clear,
// random fill/drain cycles and a long response stall.
// ---------------------------------------------------------------------------
module tb_positional_list_engine_top;
   import plc_pkg::*;

   localparam int                 CAPACITY     = 64;
   localparam logic [FUNC_W-1:0]  FUNC_UNUSED  = 3'd7;
   localparam int                 HOLD_CYCLES  = 120;
   localparam int                 DRAIN_LIMIT  = 2000;
   localparam int                 REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] value;
      logic [POS_W-1:0]         position;
   } list_request_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic                     ok;
      logic signed [WORD_W-1:0] removed_value;
      logic [COUNT_W-1:0]       entry_count;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   plc_req_if req_bus ();
   plc_rsp_if rsp_bus ();

   positional_list_engine_top #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow list and the responses still owed by the engine
   logic signed [WORD_W-1:0] shadow_words [CAPACITY];
   int                       shadow_count;
   list_result_type          owed_results [$];

   int send_idle_pct;
   int recv_idle_pct;
   int stall_requests;
   int stall_served;
   int hold_left;
   int mismatch_count;
   int beats_sent;
   int beats_checked;
   int func_seen [8];
   int ok_seen;
   int full_rejects;
   int empty_rejects;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   initial begin
      #400_000;
      $display("Test completed with failures");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Shadow list
   // -------------------------------------------------------------------------
   function automatic void shadow_put(input int slot, input logic signed [WORD_W-1:0] word);
      for (int i = shadow_count; i > slot; i--)
         shadow_words[i] = shadow_words[i-1];
      shadow_words[slot] = word;
      shadow_count++;
   endfunction

   function automatic logic signed [WORD_W-1:0] shadow_take(input int slot);
      logic signed [WORD_W-1:0] word;
      word = shadow_words[slot];
      for (int i = slot; i < shadow_count - 1; i++)
         shadow_words[i] = shadow_words[i+1];
      shadow_count--;
      return word;
   endfunction

   // Apply one accepted request to the shadow list and return its response
   function automatic list_result_type apply_to_shadow_list(input list_request_type req);
      list_result_type res;
      int              pos;
      pos               = int'(req.position);
      res.func          = req.func;
      res.ok            = 1'b0;
      res.removed_value = '0;
      case (req.func)
         FUNC_ADD_FRONT: begin
            if (shadow_count < CAPACITY) begin
               shadow_put(0, req.value);
               res.ok = 1'b1;
            end
         end
         FUNC_ADD_END: begin
            if (shadow_count < CAPACITY) begin
               shadow_put(shadow_count, req.value);
               res.ok = 1'b1;
            end
         end
         FUNC_INSERT_AT: begin
            if (pos >= 1 && pos <= shadow_count + 1 && shadow_count < CAPACITY) begin
               shadow_put(pos - 1, req.value);
               res.ok = 1'b1;
            end
         end
         FUNC_REMOVE_FRONT: begin
            if (shadow_count > 0) begin
               res.removed_value = shadow_take(0);
               res.ok            = 1'b1;
            end
         end
         FUNC_REMOVE_END: begin
            if (shadow_count > 0) begin
               res.removed_value = shadow_take(shadow_count - 1);
               res.ok            = 1'b1;
            end
         end
         FUNC_REMOVE_AT: begin
            if (shadow_count > 0 && pos >= 1 && pos <= shadow_count) begin
               res.removed_value = shadow_take(pos - 1);
               res.ok            = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            shadow_count = 0;
            res.ok       = 1'b1;
         end
         default: ;
      endcase
      res.entry_count = shadow_count[COUNT_W-1:0];
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Send one beat, optionally after an idle gap; return once it is accepted
   task automatic send_request(input list_request_type req);
      list_result_type res;
      int              count_before;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= req.func;
      req_bus.value_in <= req.value;
      req_bus.position <= req.position;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      count_before = shadow_count;
      res          = apply_to_shadow_list(req);
      owed_results.push_back(res);
      beats_sent++;
      func_seen[req.func]++;
      if (res.ok)
         ok_seen++;
      else if (count_before == CAPACITY && req.func <= FUNC_INSERT_AT)
         full_rejects++;
      else if (count_before == 0 && req.func inside {FUNC_REMOVE_FRONT, FUNC_REMOVE_END,
                                                     FUNC_REMOVE_AT})
         empty_rejects++;
   endtask

   task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [WORD_W-1:0] value,
                          input int position);
      list_request_type req;
      req.func     = func;
      req.value    = value;
      req.position = position[POS_W-1:0];
      send_request(req);
   endtask

   // Mostly random words, with the extremes now and then
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Add at front, end or a legal position
   task automatic send_grow();
      case ($urandom_range(0, 2))
         0:       send_op(FUNC_ADD_FRONT, pick_word(), $urandom_range(0, 127));
         1:       send_op(FUNC_ADD_END, pick_word(), $urandom_range(0, 127));
         default: send_op(FUNC_INSERT_AT, pick_word(), $urandom_range(1, shadow_count + 1));
      endcase
   endtask

   // Remove from front, end or a legal position
   task automatic send_shrink();
      case ($urandom_range(0, 2))
         0:       send_op(FUNC_REMOVE_FRONT, $urandom, $urandom_range(0, 127));
         1:       send_op(FUNC_REMOVE_END, $urandom, $urandom_range(0, 127));
         default: send_op(FUNC_REMOVE_AT, $urandom,
                          $urandom_range(1, (shadow_count > 0) ? shadow_count : 1));
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------
   // Drive ready: honor a long hold when asked, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_served != stall_requests) begin
         stall_served  <= stall_requests;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Check each accepted response beat against the oldest owed result
   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         beats_checked++;
         if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response beat with nothing owed: ok=%b removed=%0d count=%0d",
                        $realtime, rsp_bus.ok, rsp_bus.removed_value, rsp_bus.entry_count);
         end else begin
            exp_res = owed_results.pop_front();
            if (rsp_bus.ok !== exp_res.ok || rsp_bus.removed_value !== exp_res.removed_value ||
                rsp_bus.entry_count !== exp_res.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: func %0d mismatch: expected ok=%b removed=%0d count=%0d, ",
                            "got ok=%b removed=%0d count=%0d"}, $realtime, exp_res.func,
                           exp_res.ok, exp_res.removed_value, exp_res.entry_count,
                           rsp_bus.ok, rsp_bus.removed_value, rsp_bus.entry_count);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Edge cases on a short list: empty removes, bad positions, extremes,
   // the unused code and clear
   task automatic test_directed();
      send_op(FUNC_REMOVE_FRONT, '0, 0);
      send_op(FUNC_REMOVE_END, '0, 0);
      send_op(FUNC_REMOVE_AT, '0, 1);
      send_op(FUNC_INSERT_AT, 32'sh1234_5678, 0);
      send_op(FUNC_INSERT_AT, 32'sh1234_5678, 2);
      send_op(FUNC_INSERT_AT, 32'sh8000_0000, 1);
      send_op(FUNC_ADD_FRONT, 32'sh7FFF_FFFF, 127);
      send_op(FUNC_ADD_END, -32'sd1, 0);
      send_op(FUNC_ADD_END, '0, 0);
      send_op(FUNC_INSERT_AT, 32'sh5A5A_5A5A, 5);
      send_op(FUNC_INSERT_AT, 32'shA5A5_A5A5, 7);
      send_op(FUNC_INSERT_AT, 32'shA5A5_A5A5, 127);
      send_op(FUNC_INSERT_AT, 32'shA5A5_A5A5, 3);
      send_op(FUNC_REMOVE_AT, '0, 0);
      send_op(FUNC_REMOVE_AT, '0, 7);
      send_op(FUNC_REMOVE_AT, '0, 127);
      send_op(FUNC_REMOVE_AT, '0, 2);
      send_op(FUNC_REMOVE_FRONT, '1, 127);
      send_op(FUNC_REMOVE_END, '1, 127);
      send_op(FUNC_UNUSED, 32'shFFFF_FFFF, 127);
      send_op(FUNC_CLEAR, 32'shFFFF_FFFF, 127);
      send_op(FUNC_REMOVE_AT, '0, 1);
      send_op(FUNC_ADD_FRONT, 32'sh0F0F_0F0F, 0);
      send_op(FUNC_CLEAR, '0, 0);
   endtask

   // Fill to capacity, bounce off the full list, drain, bounce off empty
   task automatic test_full_list_cycle();
      while (shadow_count < CAPACITY)
         send_grow();
      send_op(FUNC_ADD_FRONT, pick_word(), 0);
      send_op(FUNC_ADD_END, pick_word(), 0);
      send_op(FUNC_INSERT_AT, pick_word(), $urandom_range(1, CAPACITY));
      send_op(FUNC_INSERT_AT, pick_word(), CAPACITY + 1);
      send_op(FUNC_REMOVE_AT, '0, CAPACITY + 1);
      send_op(FUNC_REMOVE_AT, '0, CAPACITY);
      while (shadow_count > 0)
         send_shrink();
      send_op(FUNC_REMOVE_FRONT, '0, 0);
      send_op(FUNC_REMOVE_AT, '0, 1);
   endtask

   // Well-formed traffic that drifts the list length, with some raw noise
   task automatic test_random_mix(input int n_items);
      int grow_pct;
      list_request_type req;
      grow_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0)
            grow_pct = $urandom_range(15, 85);
         if ($urandom_range(0, 99) < 15) begin
            req.func     = FUNC_W'($urandom_range(0, 7));
            req.value    = $urandom;
            req.position = POS_W'($urandom_range(0, 127));
            send_request(req);
         end else if ($urandom_range(0, 99) < 2) begin
            send_op(FUNC_CLEAR, $urandom, $urandom_range(0, 127));
         end else if ($urandom_range(0, 99) < grow_pct) begin
            send_grow();
         end else begin
            send_shrink();
         end
      end
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      stall_requests++;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 2)
            send_shrink();
         else
            send_grow();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      int waited;
      int failures;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= FUNC_ADD_FRONT;
      req_bus.value_in <= '0;
      req_bus.position <= '0;
      shadow_count   = 0;
      stall_requests = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();

      // sender idles rarely, receiver often; then the reverse; then neither
      send_idle_pct = 7;
      recv_idle_pct = 59;
      test_full_list_cycle();
      test_random_mix(320);

      send_idle_pct = 59;
      recv_idle_pct = 7;
      test_full_list_cycle();
      test_random_mix(320);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_full_list_cycle();
      test_random_mix(290);

      req_bus.valid <= 1'b0;
      waited = 0;
      while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      failures = mismatch_count + owed_results.size();
      if (owed_results.size() != 0)
         $display("%0d response beats never arrived", owed_results.size());
      if (failures > REPORT_LIMIT)
         $display("%0d mismatches in total", failures);

      $display("Sent %0d request beats, checked %0d responses, %0d succeeded.",
               beats_sent, beats_checked, ok_seen);
      $display("Per code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; full rejects %0d, %s %0d",
               func_seen[0], func_seen[1], func_seen[2], func_seen[3], func_seen[4],
               func_seen[5], func_seen[6], func_seen[7], full_rejects, "empty rejects",
               empty_rejects);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
